FILE: rtl/frc_pkg.sv
package frc_pkg;

  typedef enum logic [1:0] {
    KIND_BEACON  = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_CONTROL = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_MAGIC     = 3'd1,
    ST_BAD_LENGTH    = 3'd2,
    ST_MANY_SAMPLES  = 3'd3,
    ST_BAD_CRC       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_BEACON_MAGIC  = 2'd0,
    REG_DATA_MAGIC    = 2'd1,
    REG_CONTROL_MAGIC = 2'd2
  } reg_index_t;

  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [15:0] MAX_SAMPLES = 16'd1024;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [15:0] BEACON_BODY  = 16'd36;
  localparam logic [15:0] CONTROL_BODY = 16'd12;
  localparam logic [15:0] DATA_BODY    = 16'd40;
  localparam logic [16:0] BEACON_LEN   = 17'd40;
  localparam logic [16:0] CONTROL_LEN  = 17'd16;
  localparam logic [16:0] DATA_MIN_LEN = 17'd44;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } frc_in_t;

  typedef struct packed {
    status_t     status;
    kind_t       frame_kind;
    logic [7:0]  code_byte;
    logic [7:0]  flags_byte;
    logic [15:0] sample_count;
    logic [31:0] word_at_eight;
  } frc_out_t;

  // reflected crc-32, one byte, eight unrolled steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

FILE: rtl/frame_receive_checker_unit.sv
// frame receive checker
// in channel (in_valid/in_ready/in_item) takes one frame byte per item, with
// last_byte set on the final byte. the out channel (out_valid/out_ready/
// out_item) gives one result per frame: status, kind, bytes 4 and 5, sample
// count and the word at offset 8.
// configuration: cfg_write with cfg_index 0/1/2 writes the beacon, data and
// control magic words; other indexes are ignored. write only while idle.
// a byte accepted is held in the input register and then processed into the
// frame state; the result of a last byte is registered into the out register.
// throughput: one byte per cycle unless a last byte stalls (below), set by the
// eight-step crc update and header/length checks between input and result registers.
// stall: while a result waits on out_ready, non-last bytes keep flowing; a
// second last byte holds in the input register and in_ready drops.
// reset (synchronous rst): magic words cleared, frame state back to position
// zero with crc all ones, both registers empty.
module frame_receive_checker_unit
  import frc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  frc_in_t     in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output frc_out_t    out_item,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] beacon_magic, data_magic, control_magic;

  logic        s1_valid;
  frc_in_t     s1;

  logic [15:0] byte_position, byte_position_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] body_crc, body_crc_next;
  logic [31:0] stored_crc, stored_crc_next;
  logic [31:0] magic_shift, magic_shift_next;
  kind_t       kind_seen, kind_seen_next;
  logic [7:0]  header_code, header_code_next;
  logic [7:0]  header_flags, header_flags_next;
  logic [15:0] header_count, header_count_next;
  logic [31:0] header_word, header_word_next;

  logic        proc;
  logic [7:0]  b;
  logic [15:0] p;
  logic [16:0] len;
  logic [15:0] body;
  logic [16:0] body_end;
  logic [15:0] off;
  logic [17:0] need_len;
  frc_out_t    res;

  assign proc     = s1_valid && (!s1.last_byte || !out_valid || out_ready);
  assign in_ready = !s1_valid || proc;
  assign b        = s1.data_byte;
  assign p        = byte_position;
  assign len      = {1'b0, p} + 17'd1;

  always_comb begin
    magic_shift_next  = magic_shift;
    kind_seen_next    = kind_seen;
    header_code_next  = header_code;
    header_flags_next = header_flags;
    header_count_next = header_count;
    header_word_next  = header_word;
    if (p < 16'd4) begin
      magic_shift_next = magic_shift | (32'(b) << {p[1:0], 3'b000});
      if (p == 16'd3) begin
        if (magic_shift_next == beacon_magic) begin
          kind_seen_next = KIND_BEACON;
        end else if (magic_shift_next == data_magic) begin
          kind_seen_next = KIND_DATA;
        end else if (magic_shift_next == control_magic) begin
          kind_seen_next = KIND_CONTROL;
        end else begin
          kind_seen_next = KIND_UNKNOWN;
        end
      end
    end else if (p == 16'd4) begin
      header_code_next = b;
    end else if (p == 16'd5) begin
      header_flags_next = b;
    end else if (p == 16'd6) begin
      header_count_next[7:0] = b;
    end else if (p == 16'd7) begin
      header_count_next[15:8] = b;
    end else if (p < 16'd12) begin
      header_word_next = header_word | (32'(b) << {p[1:0], 3'b000});
    end

    running_crc_next = crc_byte(running_crc, b);

    // body length from the settled header; position and kind only matter past byte 7
    unique case (kind_seen)
      KIND_BEACON:  body = BEACON_BODY;
      KIND_CONTROL: body = CONTROL_BODY;
      KIND_DATA:    body = (p >= 16'd8 && header_count <= MAX_SAMPLES) ?
                           DATA_BODY + {header_count[14:0], 1'b0} : 16'd0;
      default:      body = 16'd0;
    endcase
    body_end = {1'b0, body} + 17'd4;
    off      = p - body;

    body_crc_next   = body_crc;
    stored_crc_next = stored_crc;
    if (body != 16'd0) begin
      if (len == {1'b0, body}) begin
        body_crc_next = ~running_crc_next;
      end
      if (p >= body && {1'b0, p} < body_end) begin
        stored_crc_next = stored_crc | (32'(b) << {off[1:0], 3'b000});
      end
    end

    byte_position_next = (p != POS_MAX) ? p + 16'd1 : p;

    // result of a last byte
    need_len = {1'b0, DATA_MIN_LEN} + {1'b0, header_count_next, 1'b0};
    res.frame_kind    = kind_seen_next;
    res.code_byte     = header_code_next;
    res.flags_byte    = header_flags_next;
    res.word_at_eight = header_word_next;
    res.sample_count  = 16'd0;
    unique case (kind_seen_next)
      KIND_BEACON: begin
        if (len != BEACON_LEN) begin
          res.status = ST_BAD_LENGTH;
        end else begin
          res.status = (stored_crc_next == body_crc_next) ? ST_OK : ST_BAD_CRC;
        end
      end
      KIND_CONTROL: begin
        if (len != CONTROL_LEN) begin
          res.status = ST_BAD_LENGTH;
        end else begin
          res.status = (stored_crc_next == body_crc_next) ? ST_OK : ST_BAD_CRC;
        end
      end
      KIND_DATA: begin
        res.sample_count = header_count_next;
        if (len < DATA_MIN_LEN) begin
          res.status = ST_BAD_LENGTH;
        end else if (header_count_next > MAX_SAMPLES) begin
          res.status = ST_MANY_SAMPLES;
        end else if ({1'b0, len} < need_len) begin
          res.status = ST_BAD_LENGTH;
        end else begin
          res.status = (stored_crc_next == body_crc_next) ? ST_OK : ST_BAD_CRC;
        end
      end
      default: res.status = ST_BAD_MAGIC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beacon_magic  <= 32'd0;
      data_magic    <= 32'd0;
      control_magic <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BEACON_MAGIC:  beacon_magic  <= cfg_data;
        REG_DATA_MAGIC:    data_magic    <= cfg_data;
        REG_CONTROL_MAGIC: control_magic <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1 <= in_item;
    end
    if (proc && s1.last_byte) begin
      out_item <= res;
    end
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      byte_position <= 16'd0;
      running_crc   <= CRC_INIT;
      body_crc      <= 32'd0;
      stored_crc    <= 32'd0;
      magic_shift   <= 32'd0;
      kind_seen     <= KIND_UNKNOWN;
      header_code   <= 8'd0;
      header_flags  <= 8'd0;
      header_count  <= 16'd0;
      header_word   <= 32'd0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (proc && s1.last_byte) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (proc) begin
        if (s1.last_byte) begin
          byte_position <= 16'd0;
          running_crc   <= CRC_INIT;
          body_crc      <= 32'd0;
          stored_crc    <= 32'd0;
          magic_shift   <= 32'd0;
          kind_seen     <= KIND_UNKNOWN;
          header_code   <= 8'd0;
          header_flags  <= 8'd0;
          header_count  <= 16'd0;
          header_word   <= 32'd0;
        end else begin
          byte_position <= byte_position_next;
          running_crc   <= running_crc_next;
          body_crc      <= body_crc_next;
          stored_crc    <= stored_crc_next;
          magic_shift   <= magic_shift_next;
          kind_seen     <= kind_seen_next;
          header_code   <= header_code_next;
          header_flags  <= header_flags_next;
          header_count  <= header_count_next;
          header_word   <= header_word_next;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    proc && s1.last_byte |=> byte_position == 16'd0 && running_crc == CRC_INIT)
    else $error("frame state not cleared after last item");

  a_position_step: assert property (@(posedge clk) disable iff (rst)
    proc && !s1.last_byte && byte_position != POS_MAX
    |=> byte_position == $past(byte_position) + 16'd1)
    else $error("byte position did not advance");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(proc && s1.last_byte))
    else $error("result without a last item");

  a_kind_early: assert property (@(posedge clk) disable iff (rst)
    kind_seen != KIND_UNKNOWN |-> byte_position >= 16'd4)
    else $error("kind known before magic complete");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s1.last_byte && out_valid && !out_ready)
    else $error("input stalled without a waiting result");
`endif

endmodule

FILE: test/tb_top.sv
module tb_top;
  import frc_pkg::*;

  localparam int LIMIT = 1_200_000;
  localparam logic [1:0] REG_SPARE = 2'd3;

  // frame shapes and defects used by the generator
  localparam int SH_RUNT     = 0;
  localparam int SH_BEACON   = 1;
  localparam int SH_CONTROL  = 2;
  localparam int SH_DATA     = 3;
  localparam int SH_STRANGER = 4;
  localparam int FL_NONE     = 0;
  localparam int FL_CRC      = 1;
  localparam int FL_CUT      = 2;

  // unknown magic, header bytes at their extremes
  localparam logic [127:0] STRANGE_HDR = 128'hFF00AA55_7FFE8001_FF0000FF_FFFFFFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  frc_in_t     in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  frc_out_t    out_item;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  frame_receive_checker_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  frc_in_t     byte_q[$];
  frc_out_t    verdict_q[$];
  logic [7:0]  frame_buf[$];

  // predictor copy of the magic registers and frame state
  logic [31:0] magic_reg [0:2];
  logic [15:0] fr_pos;
  logic [31:0] fr_crc;
  logic [31:0] fr_body_crc;
  logic [31:0] fr_stored_crc;
  logic [31:0] fr_magic;
  kind_t       fr_kind;
  logic [7:0]  fr_code;
  logic [7:0]  fr_flags;
  logic [15:0] fr_count;
  logic [31:0] fr_word;

  int          cycles = 0;
  int          err_cnt = 0;
  int          rx_cnt = 0;
  int          stim_bytes = 0;
  int          stim_frames = 0;
  bit          in_took = 1'b0;
  int          gap_left = 0;
  int          burst_left = 8;
  int          hold_left = 0;
  int          next_hold = 20;
  logic [9:0]  ready_tick = '0;

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = {1'b0, r[31:1]} ^ (fb ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  task automatic clear_frame;
    fr_pos = '0;
    fr_crc = CRC_INIT;
    fr_body_crc = '0;
    fr_stored_crc = '0;
    fr_magic = '0;
    fr_kind = KIND_UNKNOWN;
    fr_code = '0;
    fr_flags = '0;
    fr_count = '0;
    fr_word = '0;
  endtask

  task automatic absorb_frame_byte(input frc_in_t it);
    logic [7:0]  b;
    int unsigned p;
    int unsigned len;
    int unsigned body;
    int unsigned cnt;
    bit          crc_ok;
    frc_out_t    v;
    b = it.data_byte;
    p = fr_pos;
    len = p + 1;
    if (p < 4) begin
      fr_magic = fr_magic | (32'(b) << (8 * p));
      if (p == 3) begin
        if (fr_magic == magic_reg[REG_BEACON_MAGIC]) fr_kind = KIND_BEACON;
        else if (fr_magic == magic_reg[REG_DATA_MAGIC]) fr_kind = KIND_DATA;
        else if (fr_magic == magic_reg[REG_CONTROL_MAGIC]) fr_kind = KIND_CONTROL;
        else fr_kind = KIND_UNKNOWN;
      end
    end else if (p == 4) begin
      fr_code = b;
    end else if (p == 5) begin
      fr_flags = b;
    end else if (p < 8) begin
      fr_count = fr_count | (16'(b) << (8 * (p - 6)));
    end else if (p < 12) begin
      fr_word = fr_word | (32'(b) << (8 * (p - 8)));
    end
    fr_crc = crc32_step(fr_crc, b);
    cnt = fr_count;
    body = 0;
    if (fr_kind == KIND_BEACON) body = BEACON_BODY;
    else if (fr_kind == KIND_CONTROL) body = CONTROL_BODY;
    else if (fr_kind == KIND_DATA && p >= 8 && fr_count <= MAX_SAMPLES) body = DATA_BODY + 2 * cnt;
    if (body != 0) begin
      if (p + 1 == body) fr_body_crc = ~fr_crc;
      if (p >= body && p < body + 4) fr_stored_crc = fr_stored_crc | (32'(b) << (8 * (p - body)));
    end
    if (fr_pos != POS_MAX) fr_pos = fr_pos + 1'b1;
    if (it.last_byte) begin
      crc_ok = (fr_stored_crc == fr_body_crc);
      v.frame_kind = fr_kind;
      v.code_byte = fr_code;
      v.flags_byte = fr_flags;
      v.word_at_eight = fr_word;
      v.sample_count = '0;
      case (fr_kind)
        KIND_BEACON, KIND_CONTROL: begin
          if (len != ((fr_kind == KIND_BEACON) ? BEACON_LEN : CONTROL_LEN)) v.status = ST_BAD_LENGTH;
          else if (crc_ok) v.status = ST_OK;
          else v.status = ST_BAD_CRC;
        end
        KIND_DATA: begin
          v.sample_count = fr_count;
          if (len < DATA_MIN_LEN) v.status = ST_BAD_LENGTH;
          else if (fr_count > MAX_SAMPLES) v.status = ST_MANY_SAMPLES;
          else if (len < DATA_MIN_LEN + 2 * cnt) v.status = ST_BAD_LENGTH;
          else if (crc_ok) v.status = ST_OK;
          else v.status = ST_BAD_CRC;
        end
        default: begin
          v.status = ST_BAD_MAGIC;
        end
      endcase
      verdict_q.push_back(v);
      clear_frame();
    end
  endtask

  // queues the first keep bytes of frame_buf, then extra random bytes
  task automatic send_buf(input int keep, input int extra);
    frc_in_t it;
    int      total;
    total = keep + extra;
    for (int i = 0; i < total; i++) begin
      it.data_byte = (i < keep) ? frame_buf[i] : 8'($urandom);
      it.last_byte = (i == total - 1);
      byte_q.push_back(it);
    end
  endtask

  task automatic make_frame(input int shape, input int unsigned cnt, input int flaw,
                            input int extra);
    logic [31:0] m;
    logic [31:0] c;
    int unsigned body_n;
    int          keep;
    int          k;
    int          which;
    frame_buf.delete();
    if (shape == SH_RUNT) begin
      k = $urandom_range(1, 11);
      which = $urandom_range(0, 2);
      for (int i = 0; i < k; i++) frame_buf.push_back(8'($urandom));
      if (k >= 4 && $urandom_range(0, 1) == 1) begin
        for (int i = 0; i < 4; i++) frame_buf[i] = magic_reg[which][8*i +: 8];
      end
      keep = k;
    end else begin
      case (shape)
        SH_BEACON: begin
          m = magic_reg[REG_BEACON_MAGIC];
          body_n = BEACON_BODY;
        end
        SH_CONTROL: begin
          m = magic_reg[REG_CONTROL_MAGIC];
          body_n = CONTROL_BODY;
        end
        SH_DATA: begin
          m = magic_reg[REG_DATA_MAGIC];
          if (cnt <= MAX_SAMPLES) body_n = DATA_BODY + 2 * cnt;
          else body_n = DATA_BODY + $urandom_range(0, 8);
        end
        default: begin
          m = $urandom;
          body_n = ($urandom_range(0, 1) == 1) ? BEACON_BODY : CONTROL_BODY;
        end
      endcase
      for (int i = 0; i < 4; i++) frame_buf.push_back(m[8*i +: 8]);
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(8'($urandom));
      if (shape == SH_DATA) begin
        frame_buf.push_back(cnt[7:0]);
        frame_buf.push_back(cnt[15:8]);
      end
      while (frame_buf.size() < body_n) frame_buf.push_back(8'($urandom));
      c = CRC_INIT;
      for (int i = 0; i < frame_buf.size(); i++) c = crc32_step(c, frame_buf[i]);
      c = ~c;
      for (int i = 0; i < 4; i++) frame_buf.push_back(c[8*i +: 8]);
      keep = frame_buf.size();
      if (flaw == FL_CRC) begin
        k = $urandom_range(4, keep - 1);
        frame_buf[k] = frame_buf[k] ^ (8'd1 << $urandom_range(0, 7));
      end else if (flaw == FL_CUT) begin
        keep = $urandom_range(1, keep - 1);
      end
    end
    send_buf(keep, extra);
  endtask

  task automatic random_frame;
    int          pick;
    int          shape;
    int          flaw;
    int          extra;
    int          n0;
    int unsigned cnt;
    pick = $urandom_range(0, 99);
    if (pick < 15) shape = SH_RUNT;
    else if (pick < 35) shape = SH_BEACON;
    else if (pick < 55) shape = SH_CONTROL;
    else if (pick < 85) shape = SH_DATA;
    else shape = SH_STRANGER;
    pick = $urandom_range(0, 19);
    if (pick == 0) cnt = MAX_SAMPLES + 1;
    else if (pick == 1) cnt = 32'h0000_FFFF;
    else cnt = $urandom_range(0, 6);
    pick = $urandom_range(0, 9);
    flaw = (pick < 6) ? FL_NONE : (pick < 8) ? FL_CRC : FL_CUT;
    extra = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
    n0 = byte_q.size();
    make_frame(shape, cnt, flaw, extra);
    stim_bytes += byte_q.size() - n0;
    stim_frames++;
  endtask

  task automatic set_magic(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // wait for the block to drain and go idle
  task automatic settle;
    while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sender: bursts of items with gaps between them
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_item <= byte_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_cnt >= next_hold) begin
      hold_left = 300;
      next_hold += 40;
      out_ready <= 1'b0;
    end else begin
      ready_tick++;
      case (ready_tick[9:8])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 1) == 1);
        2'd2: out_ready <= (ready_tick[1:0] == 2'd0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: config and input tracking, result checking, timeout
  always @(posedge clk) begin
    frc_out_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      in_took = 1'b0;
      if (!rst) begin
        if (cfg_write) begin
          case (cfg_index)
            REG_BEACON_MAGIC: magic_reg[REG_BEACON_MAGIC] = cfg_data;
            REG_DATA_MAGIC: magic_reg[REG_DATA_MAGIC] = cfg_data;
            REG_CONTROL_MAGIC: magic_reg[REG_CONTROL_MAGIC] = cfg_data;
            default: ;
          endcase
        end
        if (in_valid && in_ready) begin
          in_took = 1'b1;
          absorb_frame_byte(in_item);
        end
        if (out_valid && out_ready) begin
          rx_cnt++;
          if (verdict_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10) $display("unexpected result at cycle %0d", cycles);
          end else begin
            want = verdict_q.pop_front();
            if (out_item.status !== want.status || out_item.frame_kind !== want.frame_kind ||
                out_item.code_byte !== want.code_byte ||
                out_item.flags_byte !== want.flags_byte ||
                out_item.sample_count !== want.sample_count ||
                out_item.word_at_eight !== want.word_at_eight) begin
              err_cnt++;
              if (err_cnt <= 10) begin
                $display("result %0d: expected st=%0d kind=%0d code=%h flags=%h cnt=%h word=%h",
                         rx_cnt, want.status, want.frame_kind, want.code_byte,
                         want.flags_byte, want.sample_count, want.word_at_eight);
                $display("result %0d: actual   st=%0d kind=%0d code=%h flags=%h cnt=%h word=%h",
                         rx_cnt, out_item.status, out_item.frame_kind, out_item.code_byte,
                         out_item.flags_byte, out_item.sample_count, out_item.word_at_eight);
              end
            end
          end
        end
      end
    end
  end

  initial begin
    logic [31:0] m;
    for (int i = 0; i < 3; i++) magic_reg[i] = '0;
    clear_frame();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all magic words zero: short frames, priority with equal words, unknown magic
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    send_buf(1, 0);
    frame_buf.delete();
    repeat (3) frame_buf.push_back(8'h00);
    send_buf(3, 0);
    frame_buf.delete();
    repeat (4) frame_buf.push_back(8'h00);
    send_buf(4, 0);
    frame_buf.delete();
    for (int i = 0; i < 16; i++) frame_buf.push_back(STRANGE_HDR[8*i +: 8]);
    send_buf(16, 0);
    settle();

    // extreme magic words, plus a short data frame whose count is at the limit
    set_magic(REG_BEACON_MAGIC, 32'hFFFF_FFFF);
    set_magic(REG_DATA_MAGIC, 32'h0000_0000);
    set_magic(REG_CONTROL_MAGIC, 32'h8000_0001);
    repeat (10) random_frame();
    frame_buf.delete();
    for (int i = 0; i < 4; i++) frame_buf.push_back(magic_reg[REG_DATA_MAGIC][8*i +: 8]);
    frame_buf.push_back(8'h5A);
    frame_buf.push_back(8'hA5);
    frame_buf.push_back(MAX_SAMPLES[7:0]);
    frame_buf.push_back(MAX_SAMPLES[15:8]);
    while (frame_buf.size() < 48) frame_buf.push_back(8'($urandom));
    send_buf(48, 0);
    settle();

    // data and control share a word, unused index
    m = $urandom;
    set_magic(REG_BEACON_MAGIC, $urandom);
    set_magic(REG_DATA_MAGIC, m);
    set_magic(REG_CONTROL_MAGIC, m);
    set_magic(REG_SPARE, $urandom);
    repeat (10) random_frame();
    settle();

    // one word for all three kinds
    m = $urandom;
    set_magic(REG_BEACON_MAGIC, m);
    set_magic(REG_DATA_MAGIC, m);
    set_magic(REG_CONTROL_MAGIC, m);
    repeat (6) random_frame();
    settle();

    set_magic(REG_BEACON_MAGIC, $urandom);
    set_magic(REG_DATA_MAGIC, $urandom);
    set_magic(REG_CONTROL_MAGIC, $urandom);
    while (stim_bytes < 850) random_frame();
    settle();

    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
